/* sv/mbd_pkg.sv */
// Shared types and constants for the multichannel boxcar decimator.
// No dependencies; every other file references it by scoped names.
package mbd_pkg;

  localparam int SAMPLE_W   = 16;  // input sample and output average width
  localparam int ACC_W      = 24;  // per-channel accumulator width
  localparam int CHAN_OUT_W = 6;   // channel field width on the output
  localparam int LOG2_W     = 4;   // log2_window register width
  localparam int NCH_W      = 7;   // num_channels register width
  localparam int CFG_DATA_W = 7;   // widest configuration register
  localparam int CFG_IDX_W  = 2;
  localparam int FRAME_W    = 8;   // frame position within a window
  localparam int LOG2_MIN   = 1;
  localparam int LOG2_MAX   = 8;
  localparam int LOG2_RESET = 2;
  localparam int NCH_RESET  = 16;

  localparam logic [CFG_IDX_W-1:0] REG_LOG2_WINDOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_CHANNELS = 2'd1;

  // Control shared by every accumulator cell in the chain
  typedef struct packed {
    logic clear;  // restart: zero the accumulator
    logic shift;  // transaction accepted: rotate the chain by one
  } cell_ctl_t;

endpackage

/* sv/mbd_cell.sv */
// One accumulator cell of the rotating channel chain.
// Depends on mbd_pkg for widths and the cell control struct.
module mbd_cell (
  input  logic                                clk,
  input  logic                                rst,
  input  mbd_pkg::cell_ctl_t                  ctl,
  input  logic                                is_tail,
  input  logic signed [mbd_pkg::ACC_W-1:0]    from_next,
  input  logic signed [mbd_pkg::ACC_W-1:0]    feedback,
  output logic signed [mbd_pkg::ACC_W-1:0]    acc
);

  // The tail of the active ring takes the updated head sum (zero at a window's end); others take their neighbor.
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      acc <= '0;
    end else if (ctl.shift) begin
      acc <= is_tail ? feedback : from_next;
    end
  end

endmodule

/* sv/mbd_avg.sv */
// Window mean of an accumulated sum: divide by 2^k, truncating toward zero.
// Depends on mbd_pkg for widths.
module mbd_avg (
  input  logic signed [mbd_pkg::ACC_W-1:0]    sum,
  input  logic        [mbd_pkg::LOG2_W-1:0]   log2_win,
  output logic signed [mbd_pkg::SAMPLE_W-1:0] average
);

  logic                        neg;
  logic [mbd_pkg::ACC_W-1:0]   mag;
  logic [mbd_pkg::ACC_W-1:0]   quo;
  logic [mbd_pkg::ACC_W-1:0]   res;

  // Shift the magnitude so negative sums round toward zero
  always_comb begin
    neg     = sum[mbd_pkg::ACC_W-1];
    mag     = neg ? (~sum + 1'b1) : sum;
    quo     = mag >> log2_win;
    res     = neg ? (~quo + 1'b1) : quo;
    average = res[mbd_pkg::SAMPLE_W-1:0];
  end

endmodule

/* sv/multichannel_boxcar_decimator.sv */
// Multichannel boxcar decimator: per-channel accumulators in a rotating cell chain.
// Throughput: one sample per cycle; the head cell add and the shift-divide are combinational.
// Output: an average appears on m_axis in the cycle after the last sample of its window is accepted.
// The output register lets input proceed while a result waits; only an averaging
// sample waits on a full, stalled output. Reset (rst, synchronous): accumulators,
// channel and frame position clear; log2_window = 2, num_channels = 16.
module multichannel_boxcar_decimator #(
  parameter int MAX_CHANNELS = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration write port
  input  logic                              cfg_we,
  input  logic [mbd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mbd_pkg::CFG_DATA_W-1:0]    cfg_data,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [15:0]                       s_axis_tdata,   // [15:0] sample
  // output stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [23:0]                       m_axis_tdata    // [15:0] average, [21:16] channel
);

  localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int RST_N = (mbd_pkg::NCH_RESET > MAX_CHANNELS) ? MAX_CHANNELS
                                                             : mbd_pkg::NCH_RESET;
  localparam int ACC_W = mbd_pkg::ACC_W;

  // Effective configuration, clamped at write time
  logic [mbd_pkg::LOG2_W-1:0]   log2_win;
  logic [CH_W-1:0]              last_ch;
  logic [mbd_pkg::LOG2_W-1:0]   log2_win_next;
  logic [CH_W-1:0]              last_ch_next;
  logic                         restart;

  logic [CH_W-1:0]              ch_idx;
  logic [mbd_pkg::FRAME_W-1:0]  frame;
  logic [mbd_pkg::FRAME_W:0]    win_size;
  logic [mbd_pkg::FRAME_W-1:0]  win_mask;

  logic signed [ACC_W-1:0]      acc [MAX_CHANNELS];
  logic signed [ACC_W-1:0]      head_sum;
  logic signed [ACC_W-1:0]      feedback;
  logic signed [mbd_pkg::SAMPLE_W-1:0] avg;
  logic [CH_W+5:0]              ch_pad;
  logic                         emit_now;
  logic                         s_fire;
  mbd_pkg::cell_ctl_t           ctl;

  // ---------------------------------------------------------------- config
  always_comb begin
    int n_eff;
    int last_w;
    n_eff = int'(cfg_data[mbd_pkg::NCH_W-1:0]);
    if (n_eff < 1) n_eff = 1;
    if (n_eff > MAX_CHANNELS) n_eff = MAX_CHANNELS;
    last_w       = n_eff - 1;
    last_ch_next = last_w[CH_W-1:0];

    log2_win_next = cfg_data[mbd_pkg::LOG2_W-1:0];
    if (log2_win_next < mbd_pkg::LOG2_W'(mbd_pkg::LOG2_MIN)) begin
      log2_win_next = mbd_pkg::LOG2_W'(mbd_pkg::LOG2_MIN);
    end
    if (log2_win_next > mbd_pkg::LOG2_W'(mbd_pkg::LOG2_MAX)) begin
      log2_win_next = mbd_pkg::LOG2_W'(mbd_pkg::LOG2_MAX);
    end
  end

  assign restart = cfg_we && (cfg_index == mbd_pkg::REG_LOG2_WINDOW ||
                              cfg_index == mbd_pkg::REG_NUM_CHANNELS);

  always_ff @(posedge clk) begin
    if (rst) begin
      log2_win <= mbd_pkg::LOG2_W'(mbd_pkg::LOG2_RESET);
      last_ch  <= CH_W'(RST_N - 1);
    end else if (cfg_we) begin
      case (cfg_index)
        mbd_pkg::REG_LOG2_WINDOW:  log2_win <= log2_win_next;
        mbd_pkg::REG_NUM_CHANNELS: last_ch  <= last_ch_next;
        default: ;  // unknown index: ignore
      endcase
    end
  end

  // ---------------------------------------------------------------- control
  assign win_size = (mbd_pkg::FRAME_W+1)'(1) << log2_win;
  always_comb begin
    logic [mbd_pkg::FRAME_W:0] m;
    m        = win_size - 1'b1;
    win_mask = m[mbd_pkg::FRAME_W-1:0];
  end

  assign emit_now      = (frame == win_mask);
  assign s_axis_tready = !emit_now || !m_axis_tvalid || m_axis_tready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  assign ctl.clear = restart;
  assign ctl.shift = s_fire;

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      ch_idx <= '0;
      frame  <= '0;
    end else if (s_fire) begin
      if (ch_idx == last_ch) begin
        ch_idx <= '0;
        frame  <= emit_now ? '0 : frame + 1'b1;
      end else begin
        ch_idx <= ch_idx + 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- cell chain
  // Head cell holds the sum of the channel whose sample arrives next.
  assign head_sum = acc[0] + ACC_W'(signed'(s_axis_tdata));
  assign feedback = emit_now ? '0 : head_sum;

  for (genvar i = 0; i < MAX_CHANNELS; i++) begin : g_cell
    logic signed [ACC_W-1:0] nb;
    if (i == MAX_CHANNELS - 1) begin : g_end
      assign nb = feedback;
    end else begin : g_mid
      assign nb = acc[i+1];
    end
    mbd_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .is_tail   (last_ch == CH_W'(i)),
      .from_next (nb),
      .feedback  (feedback),
      .acc       (acc[i])
    );
  end

  mbd_avg u_avg (
    .sum      (head_sum),
    .log2_win (log2_win),
    .average  (avg)
  );

  // ---------------------------------------------------------------- output register
  assign ch_pad = {6'd0, ch_idx};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s_fire && emit_now) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire && emit_now) begin
      m_axis_tdata <= {2'b00, ch_pad[5:0], avg};
    end
  end

  // ---------------------------------------------------------------- checks
  a_ch_in_ring: assert property (@(posedge clk) disable iff (rst)
    ch_idx <= last_ch)
    else $error("channel index beyond active ring");

  a_frame_in_window: assert property (@(posedge clk) disable iff (rst)
    frame <= win_mask)
    else $error("frame position beyond window");

  a_emit_loads_output: assert property (@(posedge clk) disable iff (rst)
    (s_fire && emit_now) |=> m_axis_tvalid)
    else $error("averaging transaction did not load output register");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (s_fire && emit_now) |-> (!m_axis_tvalid || m_axis_tready))
    else $error("pending average overwritten");

endmodule
